[rtl/core/ksdf_pkg.sv]
`timescale 1ns / 1ps

package ksdf_pkg;

  localparam int unsigned KeyW     = 8;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned KeyCntW  = 4;
  localparam int unsigned DebW     = 16;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned HeldW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned OutDataW = 16;

  localparam logic [DebW-1:0] DebounceReset = 16'd20;

  localparam logic FuncTick = 1'b0;
  localparam logic FuncRead = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESS_MASK = 2'd0,
    CFG_KEY_COUNT  = 2'd1,
    CFG_KEY_CODES  = 2'd2,
    CFG_DEBOUNCE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             push;
    logic             dropped;
    logic             busy;
    logic [CodeW-1:0] code;
  } scan_res_t;

endpackage

[rtl/core/key_scan_debounce_fifo_unit.sv]
// Debounced key scanner with a FIFO of key codes. Each input item is a 1 ms
// tick carrying the pin levels (tuser = 0) or a read that pops the oldest code
// (tuser = 1); every item yields exactly one result item. One item is taken
// per clock while the result register is empty or moving on: the scan state,
// FIFO pointers and code memory all update in the cycle the item is accepted.
// The result passes through a result register and an output register, so the
// input keeps accepting while one result waits on a stalled output. The user
// must write registers through cfg_we_i/cfg_idx_i/cfg_wdata_i only while no
// item is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps

module key_scan_debounce_fifo_unit import ksdf_pkg::*; #(
  parameter int unsigned KEYS       = 8,
  parameter int unsigned FIFO_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [KeyW-1:0]     s_axis_tdata,  // key_levels[7:0]
  input  logic                s_axis_tuser,  // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // read_code[7:0], read_valid, key_stored,
                                             // key_dropped, fifo_level[3:0], scan_busy
);

  typedef struct packed {
    logic              busy;
    logic [LevelW-1:0] level;
    logic              dropped;
    logic              stored;
    logic              rvalid;
  } stage_t;

  logic              accept, tick, rd_req, pop, full;
  logic [LevelW-1:0] level;
  logic [CodeW-1:0]  rdata;
  scan_res_t         scan_res;

  logic                r_valid_q, o_valid_q, r_move;
  stage_t              r_q, r_d;
  logic [OutDataW-1:0] o_data_q;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign tick   = accept && (s_axis_tuser == FuncTick);
  assign rd_req = accept && (s_axis_tuser == FuncRead);

  ksdf_scan #(.KEYS(KEYS)) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tick_i      (tick),
    .levels_i    (s_axis_tdata),
    .full_i      (full),
    .res_o       (scan_res)
  );

  ksdf_fifo #(.SLOTS(FIFO_SLOTS)) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (scan_res.push),
    .code_i    (scan_res.code),
    .pop_req_i (rd_req),
    .pop_o     (pop),
    .full_o    (full),
    .level_o   (level),
    .rdata_o   (rdata)
  );

  assign r_d.busy    = scan_res.busy;
  assign r_d.level   = level;
  assign r_d.dropped = scan_res.dropped;
  assign r_d.stored  = scan_res.push;
  assign r_d.rvalid  = pop;

  assign r_move        = r_valid_q && (!o_valid_q || m_axis_tready);
  assign s_axis_tready = !r_valid_q || r_move;
  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        r_valid_q <= 1'b1;
      end else if (r_move) begin
        r_valid_q <= 1'b0;
      end
      if (r_move) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_q <= r_d;
    end
    if (r_move) begin
      o_data_q <= {r_q.busy, r_q.level, r_q.dropped, r_q.stored, r_q.rvalid,
                   r_q.rvalid ? rdata : {CodeW{1'b0}}};
    end
  end

endmodule

[rtl/core/ksdf_scan.sv]
`timescale 1ns / 1ps

module ksdf_scan import ksdf_pkg::*; #(
  parameter int unsigned KEYS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                tick_i,
  input  logic [KeyW-1:0]     levels_i,
  input  logic                full_i,
  output scan_res_t           res_o
);

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_RELEASE  = 2'd2
  } mode_e;

  localparam logic [KeyCntW-1:0] KeysMax = KeyCntW'(KEYS);

  logic [KeyW-1:0]     mask_q;
  logic [KeyCntW-1:0]  count_q;
  logic [CfgDataW-1:0] codes_q;
  logic [DebW-1:0]     deb_q;

  mode_e              mode_q, mode_d;
  logic [HeldW-1:0]   held_q, held_d;
  logic [DebW-1:0]    wait_q, wait_d;

  logic [KeyCntW-1:0] scan_n;
  logic [KEYS-1:0]    hit;
  logic [HeldW-1:0]   pick;
  logic               push, dropped;

  assign scan_n = (count_q > KeysMax) ? KeysMax : count_q;

  always_comb begin
    hit  = '0;
    pick = '0;
    for (int k = KEYS - 1; k >= 0; k--) begin
      hit[k] = (KeyCntW'(k) < scan_n) && (levels_i[k] == mask_q[k]);
      if (hit[k]) begin
        pick = HeldW'(k);
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    wait_d  = wait_q;
    push    = 1'b0;
    dropped = 1'b0;
    if (tick_i) begin
      unique case (mode_q)
        MODE_IDLE: begin
          if (|hit) begin
            held_d = pick;
            wait_d = deb_q;
            mode_d = (deb_q == '0) ? MODE_RELEASE : MODE_DEBOUNCE;
          end
        end
        MODE_DEBOUNCE: begin
          if (wait_q != '0) begin
            wait_d = wait_q - DebW'(1);
          end
          if (wait_q <= DebW'(1)) begin
            mode_d = MODE_RELEASE;
          end
        end
        MODE_RELEASE: begin
          if (levels_i[held_q] != mask_q[held_q]) begin
            if (full_i) begin
              dropped = 1'b1;
            end else begin
              push = 1'b1;
            end
            mode_d = MODE_IDLE;
          end
        end
        default: mode_d = MODE_IDLE;
      endcase
    end
  end

  assign res_o.push    = push;
  assign res_o.dropped = dropped;
  assign res_o.busy    = (mode_d != MODE_IDLE);
  assign res_o.code    = codes_q[{held_q, 3'b000} +: CodeW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      count_q <= '0;
      codes_q <= '0;
      deb_q   <= DebounceReset;
      mode_q  <= MODE_IDLE;
      held_q  <= '0;
      wait_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PRESS_MASK: mask_q  <= cfg_wdata_i[KeyW-1:0];
          CFG_KEY_COUNT:  count_q <= cfg_wdata_i[KeyCntW-1:0];
          CFG_KEY_CODES:  codes_q <= cfg_wdata_i;
          CFG_DEBOUNCE:   deb_q   <= cfg_wdata_i[DebW-1:0];
        endcase
      end
      mode_q <= mode_d;
      held_q <= held_d;
      wait_q <= wait_d;
    end
  end

endmodule

[rtl/core/ksdf_fifo.sv]
`timescale 1ns / 1ps

module ksdf_fifo import ksdf_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [CodeW-1:0]  code_i,
  input  logic              pop_req_i,
  output logic              pop_o,
  output logic              full_o,
  output logic [LevelW-1:0] level_o,
  output logic [CodeW-1:0]  rdata_o
);

  localparam int unsigned PtrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = (PtrW + 1 > LevelW) ? PtrW + 1 : LevelW;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(SLOTS - 1);
  localparam logic [CntW-1:0] SlotsC  = CntW'(SLOTS);

  logic [CodeW-1:0] mem_q [SLOTS];
  logic [CodeW-1:0] rdata_q;
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d, wr_next, rd_next;
  logic [CntW-1:0]  wr_e, rd_e, cnt;
  logic             empty;

  assign wr_next = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
  assign rd_next = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
  assign empty   = (rd_q == wr_q);
  assign full_o  = (rd_q == wr_next);
  assign pop_o   = pop_req_i && !empty;
  assign wr_d    = push_i ? wr_next : wr_q;
  assign rd_d    = pop_o ? rd_next : rd_q;

  assign wr_e    = CntW'(wr_d);
  assign rd_e    = CntW'(rd_d);
  assign cnt     = (wr_e >= rd_e) ? (wr_e - rd_e) : (wr_e + SlotsC - rd_e);
  assign level_o = cnt[LevelW-1:0];
  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= code_i;
    end
    if (pop_o) begin
      rdata_q <= mem_q[rd_q];
    end
  end

endmodule

[rtl/core/ksdf_chk.sv]
`timescale 1ns / 1ps

module ksdf_chk import ksdf_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_read_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> !m_axis_tdata[9] && !m_axis_tdata[10])
    else $error("read item also flags a key event");

  a_event_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[10]))
    else $error("key both stored and dropped");

  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("read code nonzero without a pop");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output empty");

endmodule

bind key_scan_debounce_fifo_unit ksdf_chk u_ksdf_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
